// File: rtl/i2cmrt_pkg.sv
// Package for the I2C register transfer unit: item structs, step and stage codes.
// No dependencies.
package i2cmrt_pkg;

	localparam int AckTimeoutTicks = 250;
	localparam int PostGapTicks    = 10;
	localparam int QueueDepth      = 2;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_BEGIN  = 2'd1,
		ACT_SUPPLY = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OP_WR8 = 3'd0, OP_WR16 = 3'd1, OP_BWR = 3'd2,
		OP_RD8 = 3'd3, OP_RD16 = 3'd4, OP_BRD = 3'd5
	} op_code_t;

	typedef enum logic [5:0] {
		S_IDLE, S_ST1, S_ST2, S_ST3, S_ST4, S_TXS, S_TXA, S_TXB, S_TXC,
		S_AW1, S_APOLL, S_AW2, S_RXS, S_RXA, S_RXB, S_RXC,
		S_AK1, S_AK2, S_AK3, S_AK4, S_AK5, S_WAITB,
		S_SP1, S_SP2, S_SP3, S_SP4, S_GAP
	} step_t;

	typedef enum logic [2:0] {
		G_ADDRW, G_REG, G_DHI, G_DLO, G_BURST, G_ADDRR, G_DATAR
	} stage_t;

	typedef enum logic [0:0] {
		CFG_DEVICE_ADDRESS = 1'd0,
		CFG_PHASE_LENGTH   = 1'd1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        sda_sample;
		logic [2:0]  operation;
		logic [7:0]  register_index;
		logic [15:0] write_value;
		logic [15:0] burst_length;
	} in_item_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_release;
		logic        busy_res;
		logic        need_write_byte;
		logic        byte_valid;
		logic [7:0]  read_byte;
		logic        done_res;
		logic        status;
		logic [15:0] read_value;
	} out_item_t;

	// Classified command handed from the front to the sequencer
	typedef struct packed {
		action_t     action;
		logic        sda_sample;
		logic        op_ok;
		logic [2:0]  operation;
		logic [7:0]  register_index;
		logic [15:0] write_value;
		logic [15:0] burst_length;
	} cmd_t;

endpackage

// File: rtl/i2cmrt_front.sv
// Front end: accepts input items, classifies them and queues commands.
// Depends on i2cmrt_pkg.
module i2cmrt_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cmrt_pkg::in_item_t  in_data,
	output logic                  cmd_valid,
	input  logic                  cmd_take,
	output i2cmrt_pkg::cmd_t      cmd
);
	import i2cmrt_pkg::*;

	cmd_t       fifo_q [QueueDepth];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;
	cmd_t       classified;

	// Classify the item: decode action and check the operation code
	always_comb begin
		classified.action         = action_t'(in_data.action);
		classified.sda_sample     = in_data.sda_sample;
		classified.op_ok          = (in_data.operation <= OP_BRD);
		classified.operation      = in_data.operation;
		classified.register_index = in_data.register_index;
		classified.write_value    = in_data.write_value;
		classified.burst_length   = in_data.burst_length;
	end

	assign in_stall  = (count_q == 2'(QueueDepth));
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_valid && cmd_take;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= classified;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QueueDepth)) else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("fill count lost a push");
endmodule

// File: rtl/i2cmrt_seq.sv
// Back end: registered bus sequencer; one command per cycle unless stalled.
// Depends on i2cmrt_pkg.
module i2cmrt_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_take,
	input  i2cmrt_pkg::cmd_t      cmd,
	input  logic [6:0]            device_address,
	input  logic [15:0]           phase_length,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cmrt_pkg::out_item_t out_data
);
	import i2cmrt_pkg::*;

	step_t       step_q, step_d;
	stage_t      stage_q, stage_d;
	logic [15:0] timer_q, timer_d;
	logic [3:0]  bits_q, bits_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  wait_q, wait_d;
	logic [15:0] left_q, left_d;
	logic [2:0]  op_q, op_d;
	logic [7:0]  reg_q, reg_d;
	logic [15:0] val_q, val_d;
	logic [15:0] acc_q, acc_d;
	logic        tout_q, tout_d;
	out_item_t   res, out_q;
	logic        out_valid_q;
	logic [15:0] limit, timer_inc;
	logic        phase_end;

	assign cmd_take  = cmd_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Hold state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= S_IDLE;
			stage_q <= G_ADDRW;
			timer_q <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			left_q  <= '0;
			op_q    <= '0;
			reg_q   <= '0;
			val_q   <= '0;
			acc_q   <= '0;
			tout_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				step_q  <= step_d;
				stage_q <= stage_d;
				timer_q <= timer_d;
				bits_q  <= bits_d;
				shift_q <= shift_d;
				wait_q  <= wait_d;
				left_q  <= left_d;
				op_q    <= op_d;
				reg_q   <= reg_d;
				val_q   <= val_d;
				acc_q   <= acc_d;
				tout_q  <= tout_d;
			end
			if (cmd_take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Register the result item
	always_ff @(posedge clk) begin
		if (cmd_take) out_q <= res;
	end

	assign limit     = (step_q == S_GAP) ? 16'(PostGapTicks)
	                 : ((phase_length == 16'd0) ? 16'd1 : phase_length);
	assign timer_inc = timer_q + 16'd1;
	assign phase_end = (timer_inc >= limit);

	// Next state and result
	always_comb begin
		logic       sb;
		logic       ab;
		logic       done;
		logic [15:0] ldec;
		step_d = step_q; stage_d = stage_q; timer_d = timer_q; bits_d = bits_q;
		shift_d = shift_q; wait_d = wait_q; left_d = left_q; op_d = op_q;
		reg_d = reg_q; val_d = val_q; acc_d = acc_q; tout_d = tout_q;
		done = 1'b0;
		ldec = left_q - 16'd1;
		res = '0;

		// Drive levels of the phase in force
		sb = shift_q[7];
		ab = !(left_q > 16'd1);
		res.scl_level = 1'b1; res.sda_release = 1'b1;
		case (step_q)
			S_ST3, S_SP3: begin res.scl_level = 1'b1; res.sda_release = 1'b0; end
			S_ST4, S_SP2: begin res.scl_level = 1'b0; res.sda_release = 1'b0; end
			S_TXA, S_TXC: begin res.scl_level = 1'b0; res.sda_release = sb; end
			S_TXB:        begin res.scl_level = 1'b1; res.sda_release = sb; end
			S_TXS, S_AW2, S_RXS, S_RXA, S_AK1, S_WAITB, S_SP1: begin
				res.scl_level = 1'b0; res.sda_release = 1'b1;
			end
			S_AK2, S_AK4, S_AK5: begin res.scl_level = 1'b0; res.sda_release = ab; end
			S_AK3:        begin res.scl_level = 1'b1; res.sda_release = ab; end
			default: ;
		endcase

		case (cmd.action)
			ACT_BEGIN: begin
				if (step_q == S_IDLE && cmd.op_ok) begin
					op_d = cmd.operation; reg_d = cmd.register_index;
					val_d = cmd.write_value; left_d = cmd.burst_length;
					acc_d = '0; tout_d = 1'b0; stage_d = G_ADDRW;
					wait_d = '0; bits_d = '0; shift_d = '0;
					step_d = S_ST1; timer_d = '0;
				end
			end
			ACT_SUPPLY: begin
				if (step_q == S_WAITB) begin
					left_d = ldec; shift_d = cmd.write_value[7:0]; bits_d = '0;
					step_d = S_TXS; timer_d = '0;
				end
			end
			ACT_TICK: begin
				if (step_q == S_IDLE || step_q == S_WAITB) begin
				end else if (step_q == S_APOLL) begin
					if (!cmd.sda_sample) begin step_d = S_AW2; timer_d = '0; end
					else if (wait_q >= 8'(AckTimeoutTicks)) begin
						tout_d = 1'b1; step_d = S_SP1; timer_d = '0;
					end else wait_d = wait_q + 8'd1;
				end else if (!phase_end) begin
					timer_d = timer_inc;
				end else begin
					timer_d = '0;
					case (step_q)
						S_ST1: step_d = S_ST2;
						S_ST2: step_d = S_ST3;
						S_ST3: step_d = S_ST4;
						S_ST4: begin
							shift_d = {device_address, stage_q == G_ADDRR};
							bits_d = '0; step_d = S_TXS;
						end
						S_TXS: step_d = S_TXA;
						S_TXA: step_d = S_TXB;
						S_TXB: step_d = S_TXC;
						S_TXC: begin
							shift_d = {shift_q[6:0], 1'b0};
							bits_d = bits_q + 4'd1;
							if (bits_q + 4'd1 >= 4'd8) begin wait_d = '0; step_d = S_AW1; end
							else step_d = S_TXA;
						end
						S_AW1: step_d = S_APOLL;
						S_AW2: begin
							case (stage_q)
								G_ADDRW: begin
									stage_d = G_REG; shift_d = reg_q; bits_d = '0;
									step_d = S_TXS;
								end
								G_REG: begin
									if (op_q == OP_WR8) begin
										stage_d = G_DLO; shift_d = val_q[7:0]; bits_d = '0;
										step_d = S_TXS;
									end else if (op_q == OP_WR16) begin
										stage_d = G_DHI; shift_d = val_q[15:8]; bits_d = '0;
										step_d = S_TXS;
									end else if (op_q == OP_BWR) begin
										stage_d = G_BURST;
										step_d = (left_q == 16'd0) ? S_SP1 : S_WAITB;
									end else begin
										stage_d = G_ADDRR; step_d = S_ST1;
									end
								end
								G_DHI: begin
									stage_d = G_DLO; shift_d = val_q[7:0]; bits_d = '0;
									step_d = S_TXS;
								end
								G_BURST: step_d = (left_q == 16'd0) ? S_SP1 : S_WAITB;
								G_ADDRR: begin
									logic [15:0] nl;
									nl = left_q;
									if (op_q == OP_RD8) nl = 16'd1;
									else if (op_q == OP_RD16) nl = 16'd2;
									left_d = nl; acc_d = '0;
									if (nl == 16'd0) step_d = S_SP1;
									else begin stage_d = G_DATAR; step_d = S_RXS; end
								end
								default: step_d = S_SP1;
							endcase
						end
						S_RXS: begin bits_d = '0; shift_d = '0; step_d = S_RXA; end
						S_RXA: step_d = S_RXB;
						S_RXB: begin shift_d = {shift_q[6:0], cmd.sda_sample}; step_d = S_RXC; end
						S_RXC: begin
							bits_d = bits_q + 4'd1;
							step_d = (bits_q + 4'd1 >= 4'd8) ? S_AK1 : S_RXA;
						end
						S_AK1: step_d = S_AK2;
						S_AK2: step_d = S_AK3;
						S_AK3: step_d = S_AK4;
						S_AK4: step_d = S_AK5;
						S_AK5: begin
							acc_d = {acc_q[7:0], shift_q};
							if (op_q == OP_BRD) begin res.byte_valid = 1'b1; res.read_byte = shift_q; end
							left_d = ldec;
							step_d = (ldec == 16'd0) ? S_SP1 : S_RXS;
						end
						S_SP1: step_d = S_SP2;
						S_SP2: step_d = S_SP3;
						S_SP3: step_d = S_SP4;
						S_SP4: begin
							if (!tout_q && (op_q == OP_WR8 || op_q == OP_RD8) && PostGapTicks > 0)
								step_d = S_GAP;
							else begin done = 1'b1; step_d = S_IDLE; end
						end
						default: begin done = 1'b1; step_d = S_IDLE; end
					endcase
				end
				if (done) begin
					res.status = tout_d;
					if (op_q == OP_RD8) res.read_value = tout_d ? 16'h00FF : {8'd0, acc_d[7:0]};
					else if (op_q == OP_RD16) res.read_value = tout_d ? 16'hFFFF : acc_d;
				end
			end
			default: ;
		endcase
		res.busy_res        = (step_d != S_IDLE);
		res.need_write_byte = (step_d == S_WAITB);
		res.done_res        = done;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.done_res) |-> !out_data.busy_res)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.need_write_byte) |-> out_data.busy_res)
		else $error("waiting for a byte while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

// File: rtl/i2c_master_register_transfer_unit.sv
// I2C master register transfer unit: one bus tick per item, one result per item.
// Path: each item passes through the queue, then the output register, before its result is presented.
// Throughput: one item per cycle while the output is not stalled.
// Reset: asynchronous, active low; bus idle, device_address 0, phase_length 5.
// Depends on i2cmrt_pkg, i2cmrt_front and i2cmrt_seq.
module i2c_master_register_transfer_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cmrt_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cmrt_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import i2cmrt_pkg::*;

	logic [6:0]  dev_addr_q;
	logic [15:0] phase_len_q;
	logic        cmd_valid, cmd_take;
	cmd_t        cmd;

	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q  <= 7'd0;
			phase_len_q <= 16'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data[6:0];
				CFG_PHASE_LENGTH:   phase_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cmrt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	i2cmrt_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.device_address(dev_addr_q), .phase_length(phase_len_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

// File: bench/i2c_master_register_transfer_unit_tb.sv
// Testbench for i2c_master_register_transfer_unit: directed table then random transactions,
// every result checked against an in-bench model of the bus sequencer or a fixed expected item. Depends on i2cmrt_pkg.
module i2c_master_register_transfer_unit_tb;
	import i2cmrt_pkg::*;

	localparam int RandomItems = 1700;
	localparam int CycleLimit  = 400000;
	localparam int DrainCycles = 10;

	typedef enum int {K_ITEM, K_TXN, K_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		in_item_t  it;
		bit        has_exp;
		out_item_t exp;
	} row_t;

	// one entry of the drive list: an item or a register write
	typedef struct {
		bit         is_cfg;
		cfg_index_t idx;
		logic [15:0] data;
		in_item_t   it;
	} drive_t;

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, in_stall;
	in_item_t    in_data = '0;
	logic        out_valid, out_stall = 0;
	out_item_t   out_data;
	logic        cfg_valid = 0, cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	drive_t    drive_q[$];
	out_item_t bus_expect_q[$];
	int        items_sent = 0, results_got = 0, errors = 0, cycles = 0;
	bit        long_hold_done = 0;

	// model state
	step_t       m_step;
	stage_t      m_stage;
	logic [15:0] m_timer, m_left, m_val, m_acc, m_plen;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift, m_ackw, m_reg;
	logic [2:0]  m_op;
	logic [6:0]  m_dev;
	bit          m_tout;

	i2c_master_register_transfer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic void enter(step_t s);
		m_step = s;
		m_timer = '0;
	endfunction

	function automatic void load_byte(logic [7:0] b);
		m_shift = b;
		m_bits = '0;
		enter(S_TXS);
	endfunction

	function automatic void burst_next();
		if (m_left == 0) enter(S_SP1); else enter(S_WAITB);
	endfunction

	// pick the next byte or phase once an ACK has been seen
	function automatic void on_ack();
		case (m_stage)
			G_ADDRW: begin
				m_stage = G_REG;
				load_byte(m_reg);
			end
			G_REG: begin
				if (m_op == OP_WR8) begin
					m_stage = G_DLO;
					load_byte(m_val[7:0]);
				end else if (m_op == OP_WR16) begin
					m_stage = G_DHI;
					load_byte(m_val[15:8]);
				end else if (m_op == OP_BWR) begin
					m_stage = G_BURST;
					burst_next();
				end else begin
					m_stage = G_ADDRR;
					enter(S_ST1);
				end
			end
			G_DHI: begin
				m_stage = G_DLO;
				load_byte(m_val[7:0]);
			end
			G_BURST: burst_next();
			G_ADDRR: begin
				if (m_op == OP_RD8) m_left = 1;
				else if (m_op == OP_RD16) m_left = 2;
				m_acc = '0;
				if (m_left == 0) enter(S_SP1);
				else begin
					m_stage = G_DATAR;
					enter(S_RXS);
				end
			end
			default: enter(S_SP1);
		endcase
	endfunction

	function automatic void bus_reset();
		m_dev = '0; m_plen = 16'd5;
		m_step = S_IDLE; m_timer = '0; m_bits = '0; m_shift = '0;
		m_ackw = '0; m_left = '0; m_op = '0; m_reg = '0; m_val = '0;
		m_acc = '0; m_stage = G_ADDRW; m_tout = 0;
	endfunction

	// advance the model by one item and return the bus result it gives
	function automatic out_item_t bus_step(in_item_t it);
		out_item_t o;
		logic [16:0] lim;
		logic b, a;
		o = '0;
		if (it.action == ACT_BEGIN && m_step == S_IDLE && it.operation <= 3'd5) begin
			m_op = it.operation; m_reg = it.register_index; m_val = it.write_value;
			m_left = it.burst_length; m_acc = '0; m_tout = 0; m_stage = G_ADDRW;
			m_ackw = '0; m_bits = '0; m_shift = '0;
			enter(S_ST1);
		end else if (it.action == ACT_SUPPLY && m_step == S_WAITB) begin
			m_left = m_left - 16'd1;
			load_byte(it.write_value[7:0]);
		end
		// line levels of the phase in force
		b = m_shift[7];
		a = (m_left > 16'd1) ? 1'b0 : 1'b1;
		o.scl_level = 1; o.sda_release = 1;
		case (m_step)
			S_ST3, S_SP3:   begin o.scl_level = 1; o.sda_release = 0; end
			S_ST4, S_SP2:   begin o.scl_level = 0; o.sda_release = 0; end
			S_TXA, S_TXC:   begin o.scl_level = 0; o.sda_release = b; end
			S_TXB:          begin o.scl_level = 1; o.sda_release = b; end
			S_TXS, S_AW2, S_RXS, S_RXA, S_AK1, S_WAITB, S_SP1: begin
				o.scl_level = 0; o.sda_release = 1;
			end
			S_AK2, S_AK4, S_AK5: begin o.scl_level = 0; o.sda_release = a; end
			S_AK3:          begin o.scl_level = 1; o.sda_release = a; end
			default: ;
		endcase
		if (it.action == ACT_TICK && m_step != S_IDLE && m_step != S_WAITB) begin
			if (m_step == S_APOLL) begin
				if (it.sda_sample == 0) enter(S_AW2);
				else if (m_ackw >= AckTimeoutTicks) begin
					m_tout = 1;
					enter(S_SP1);
				end else m_ackw = m_ackw + 8'd1;
			end else begin
				lim = (m_step == S_GAP) ? 17'(PostGapTicks) : {1'b0, m_plen};
				if (lim == 0) lim = 1;
				m_timer = m_timer + 16'd1;
				if ({1'b0, m_timer} >= lim) begin
					m_timer = '0;
					case (m_step)
						S_ST1: enter(S_ST2);
						S_ST2: enter(S_ST3);
						S_ST3: enter(S_ST4);
						S_ST4: load_byte(m_stage == G_ADDRR ? {m_dev, 1'b1} : {m_dev, 1'b0});
						S_TXS: enter(S_TXA);
						S_TXA: enter(S_TXB);
						S_TXB: enter(S_TXC);
						S_TXC: begin
							m_shift = m_shift << 1;
							m_bits = m_bits + 4'd1;
							if (m_bits >= 4'd8) begin
								m_ackw = '0;
								enter(S_AW1);
							end else enter(S_TXA);
						end
						S_AW1: enter(S_APOLL);
						S_AW2: on_ack();
						S_RXS: begin
							m_bits = '0; m_shift = '0;
							enter(S_RXA);
						end
						S_RXA: enter(S_RXB);
						S_RXB: begin
							m_shift = {m_shift[6:0], it.sda_sample};
							enter(S_RXC);
						end
						S_RXC: begin
							m_bits = m_bits + 4'd1;
							if (m_bits >= 4'd8) enter(S_AK1); else enter(S_RXA);
						end
						S_AK1: enter(S_AK2);
						S_AK2: enter(S_AK3);
						S_AK3: enter(S_AK4);
						S_AK4: enter(S_AK5);
						S_AK5: begin
							m_acc = {m_acc[7:0], m_shift};
							if (m_op == OP_BRD) begin
								o.byte_valid = 1;
								o.read_byte = m_shift;
							end
							m_left = m_left - 16'd1;
							if (m_left == 0) enter(S_SP1); else enter(S_RXS);
						end
						S_SP1: enter(S_SP2);
						S_SP2: enter(S_SP3);
						S_SP3: enter(S_SP4);
						S_SP4: begin
							if (!m_tout && (m_op == OP_WR8 || m_op == OP_RD8) && PostGapTicks > 0)
								enter(S_GAP);
							else begin
								o.done_res = 1;
								enter(S_IDLE);
							end
						end
						default: begin
							o.done_res = 1;
							enter(S_IDLE);
						end
					endcase
				end
			end
			if (o.done_res) begin
				o.status = m_tout;
				if (m_op == OP_RD8) o.read_value = m_tout ? 16'h00FF : {8'h00, m_acc[7:0]};
				else if (m_op == OP_RD16) o.read_value = m_tout ? 16'hFFFF : m_acc;
			end
		end
		o.busy_res = (m_step != S_IDLE);
		o.need_write_byte = (m_step == S_WAITB);
		return o;
	endfunction

	function automatic in_item_t mk(action_t act, logic s, logic [2:0] op, logic [7:0] r,
			logic [15:0] v, logic [15:0] n);
		in_item_t it;
		it.action = act; it.sda_sample = s; it.operation = op;
		it.register_index = r; it.write_value = v; it.burst_length = n;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it = in_item_t'({$urandom, $urandom});
		return it;
	endfunction

	task automatic push_item(in_item_t it, bit has_exp, out_item_t exp);
		drive_t d;
		out_item_t p;
		p = bus_step(it);
		d.is_cfg = 0; d.idx = CFG_DEVICE_ADDRESS; d.data = '0; d.it = it;
		drive_q.push_back(d);
		bus_expect_q.push_back(has_exp ? exp : p);
	endtask

	task automatic push_cfg(cfg_index_t idx, logic [15:0] v);
		drive_t d;
		d.is_cfg = 1; d.idx = idx; d.data = v; d.it = '0;
		drive_q.push_back(d);
		if (idx == CFG_DEVICE_ADDRESS) m_dev = v[6:0]; else m_plen = v;
	endtask

	// one whole transaction: begin, then ticks and burst bytes until the bus is idle
	task automatic push_txn(in_item_t req, bit ack_miss);
		in_item_t it;
		logic s;
		push_item(req, 0, '0);
		while (m_step != S_IDLE) begin
			// no stray ticks while a missing ACK is polled, so it really times out
			if (!(ack_miss && m_step == S_APOLL) && $urandom_range(0, 40) == 0)
				push_item(noise_item(), 0, '0);
			else if (m_step == S_WAITB) begin
				it = noise_item();
				it.action = ACT_SUPPLY;
				push_item(it, 0, '0);
			end else begin
				if (m_step == S_APOLL) s = ack_miss ? 1'b1 : ($urandom_range(0, 3) == 0);
				else s = $urandom_range(0, 1);
				it = noise_item();
				it.action = ACT_TICK; it.sda_sample = s;
				push_item(it, 0, '0);
			end
		end
	endtask

	task automatic build_stimulus();
		out_item_t idle_out;
		row_t rows[$];
		row_t r;
		in_item_t req;
		bit miss;
		idle_out = '0;
		idle_out.scl_level = 1; idle_out.sda_release = 1;
		bus_reset();
		// directed table
		rows = '{
			'{K_ITEM, mk(ACT_TICK, 1, 0, 0, 0, 0), 1, idle_out},
			'{K_ITEM, mk(ACT_NONE, 0, 7, 8'hFF, 16'hFFFF, 16'hFFFF), 1, idle_out},
			'{K_ITEM, mk(ACT_BEGIN, 1, 6, 8'hFF, 16'hFFFF, 16'hFFFF), 1, idle_out},
			'{K_ITEM, mk(ACT_BEGIN, 0, 7, 0, 0, 0), 1, idle_out},
			'{K_ITEM, mk(ACT_SUPPLY, 0, 0, 0, 16'hFFFF, 0), 1, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_WR8, 8'h00, 16'h0000, 0), 0, idle_out},
			'{K_CFG, mk(ACT_TICK, 0, 0, 0, 16'd127, 0), 0, idle_out},
			'{K_CFG, mk(ACT_TICK, 0, 1, 0, 16'd1, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_WR8, 8'hFF, 16'hFFFF, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_WR16, 8'hA5, 16'h8001, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_BWR, 8'h5A, 0, 16'd2), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_BWR, 8'h01, 0, 16'd0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_RD8, 8'h80, 0, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_RD16, 8'h7F, 0, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_BRD, 8'h33, 0, 16'd3), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 0, OP_BRD, 8'h44, 0, 16'd0), 0, idle_out},
			// ACK timeouts: one stop, status set, all ones read back on the read
			'{K_TXN, mk(ACT_BEGIN, 1, OP_RD16, 8'h12, 0, 0), 0, idle_out},
			'{K_TXN, mk(ACT_BEGIN, 1, OP_BWR, 8'h12, 0, 16'hFFFF), 0, idle_out},
			'{K_CFG, mk(ACT_TICK, 0, 0, 0, 16'd0, 0), 0, idle_out},
			'{K_CFG, mk(ACT_TICK, 0, 1, 0, 16'd65535, 0), 0, idle_out},
			'{K_ITEM, mk(ACT_TICK, 0, 0, 0, 0, 0), 1, idle_out}
		};
		foreach (rows[i]) begin
			r = rows[i];
			case (r.kind)
				K_ITEM: push_item(r.it, r.has_exp, r.exp);
				K_TXN: begin
					req = r.it;
					miss = req.sda_sample;
					req.sda_sample = 0;
					push_txn(req, miss);
				end
				default: push_cfg(cfg_index_t'(r.it.operation[0]), r.it.write_value);
			endcase
		end
		// random transactions under changing settings
		while (drive_q.size() < RandomItems) begin
			if ($urandom_range(0, 9) == 0) begin
				push_cfg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
				push_cfg(CFG_PHASE_LENGTH, 16'($urandom_range(1, 3)));
			end
			miss = ($urandom_range(0, 11) == 0);
			req = noise_item();
			req.action = ACT_BEGIN;
			req.operation = 3'($urandom_range(0, 5));
			if (!miss) req.burst_length = 16'($urandom_range(0, 4));
			push_txn(req, miss);
			if ($urandom_range(0, 3) == 0) push_item(noise_item(), 0, '0);
		end
	endtask

	// count accepted items
	always @(posedge clk) begin
		if (in_valid && !in_stall) items_sent <= items_sent + 1;
	end

	task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
			errors++;
		end
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (results_got >= bus_expect_q.size() || results_got >= items_sent) begin
				$display("%0t unexpected result: expected none actual %h", $time, out_data);
				errors++;
			end else begin
				e = bus_expect_q[results_got];
				check_field("scl_level", e.scl_level, out_data.scl_level);
				check_field("sda_release", e.sda_release, out_data.sda_release);
				check_field("busy_res", e.busy_res, out_data.busy_res);
				check_field("need_write_byte", e.need_write_byte, out_data.need_write_byte);
				check_field("byte_valid", e.byte_valid, out_data.byte_valid);
				check_field("read_byte", e.read_byte, out_data.read_byte);
				check_field("done_res", e.done_res, out_data.done_res);
				check_field("status", e.status, out_data.status);
				check_field("read_value", e.read_value, out_data.read_value);
			end
			results_got <= results_got + 1;
		end
	end

	// receiver: changing stall pattern plus one long hold-off
	always @(negedge clk) begin
		int mode;
		int hold;
		if (!arst_n) out_stall <= 0;
		else begin
			if (cycles % 64 == 0) mode = $urandom_range(0, 2);
			if (hold == 0 && !long_hold_done && results_got > 600) begin
				hold = 400;
				long_hold_done = 1;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1;
			end else if (mode == 0) out_stall <= 0;
			else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
			else out_stall <= ($urandom_range(0, 3) != 0);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sender: bursts with gaps; register writes only once the block has drained
	initial begin
		drive_t d;
		int burst;
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		burst = 0;
		while (drive_q.size() > 0) begin
			d = drive_q.pop_front();
			if (d.is_cfg) begin
				in_valid <= 0;
				while (results_got != items_sent) @(negedge clk);
				repeat (DrainCycles) @(negedge clk);
				cfg_valid <= 1; cfg_index <= d.idx; cfg_data <= d.data;
				do @(posedge clk); while (!cfg_ready);
				@(negedge clk);
				cfg_valid <= 0;
			end else begin
				if (burst == 0) begin
					in_valid <= 0;
					repeat ($urandom_range(0, 8)) @(negedge clk);
					burst = $urandom_range(1, 40);
				end
				burst--;
				in_valid <= 1;
				in_data <= d.it;
				do @(posedge clk); while (in_stall);
				@(negedge clk);
			end
		end
		in_valid <= 0;
		while (results_got != items_sent || items_sent != bus_expect_q.size()) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
